### hw/rtl/des_rf_pkg.sv
// ----------------------------------------------------------------------------
// des_rf_pkg
// Tables and helper functions for the DES round function: expansion E,
// the eight S-boxes and the permutation P, bits numbered as in the standard.
// ----------------------------------------------------------------------------
`default_nettype none

package des_rf_pkg;

    localparam int RH_W   = 32;
    localparam int KEY_W  = 48;
    localparam int SBOX_N = 8;

    // expansion E as source bit positions (lsb = 0), listed from output msb down
    localparam logic [4:0] E_SRC [48] = '{
        5'd0,  5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd28, 5'd27,
        5'd26, 5'd25, 5'd24, 5'd23, 5'd24, 5'd23, 5'd22, 5'd21,
        5'd20, 5'd19, 5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15,
        5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11, 5'd12, 5'd11,
        5'd10, 5'd9,  5'd8,  5'd7,  5'd8,  5'd7,  5'd6,  5'd5,
        5'd4,  5'd3,  5'd4,  5'd3,  5'd2,  5'd1,  5'd0,  5'd31
    };

    // permutation P as source bit positions (lsb = 0), listed from output msb down
    localparam logic [4:0] P_SRC [32] = '{
        5'd16, 5'd25, 5'd12, 5'd11, 5'd3,  5'd20, 5'd4,  5'd15,
        5'd31, 5'd17, 5'd9,  5'd6,  5'd27, 5'd14, 5'd1,  5'd22,
        5'd30, 5'd24, 5'd8,  5'd18, 5'd0,  5'd5,  5'd29, 5'd23,
        5'd13, 5'd19, 5'd2,  5'd26, 5'd10, 5'd21, 5'd28, 5'd7
    };

    // s-boxes S1..S8, entry index is row * 16 + column
    localparam logic [3:0] SBOX_TAB [SBOX_N][64] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd9,4'd5,4'd6,4'd11,4'd0,4'd14,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
    };

    // expansion E: 32 to 48 bits, pure wiring
    function automatic logic [KEY_W-1:0] des_expand(input logic [RH_W-1:0] r);
        logic [KEY_W-1:0] x;
        for (int i = 0; i < KEY_W; i++)
        begin
            x[KEY_W-1-i] = r[E_SRC[i]];
        end
        return x;
    endfunction

    // eight s-boxes side by side, S1 in the top group
    function automatic logic [RH_W-1:0] des_sbox_layer(input logic [KEY_W-1:0] x);
        logic [RH_W-1:0] s;
        logic [5:0]      c;
        for (int b = 0; b < SBOX_N; b++)
        begin
            c = x[KEY_W-1-6*b -: 6];
            s[RH_W-1-4*b -: 4] = SBOX_TAB[b][{c[5], c[0], c[4:1]}];
        end
        return s;
    endfunction

    // permutation P, pure wiring
    function automatic logic [RH_W-1:0] des_perm_p(input logic [RH_W-1:0] s);
        logic [RH_W-1:0] y;
        for (int i = 0; i < RH_W; i++)
        begin
            y[RH_W-1-i] = s[P_SRC[i]];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/des_round_function_top.sv
// ----------------------------------------------------------------------------
// des_round_function_top
// DES Feistel function f(R, K) on a stream: each input item carries a 32-bit
// right half and a 48-bit round subkey, each output item the 32-bit f value.
// The block is a three-stage pipeline (expansion and key mix, S-box lookup,
// permutation P into the output register): an accepted item is registered
// in mix_reg, then sbox_reg, then f_reg, which drives the output. A new item
// is taken every cycle while the downstream side keeps m_tready high. Stalls
// back up through the stages with no item lost or repeated; there is no
// configuration and no state between items.
// ----------------------------------------------------------------------------
`default_nettype none

module des_round_function_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // [31:0] right_half, [79:32] round_key
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] f_out
);

    localparam int RH_W  = des_rf_pkg::RH_W;
    localparam int KEY_W = des_rf_pkg::KEY_W;

    logic             v1_reg, v2_reg, v3_reg;
    logic [KEY_W-1:0] mix_reg;
    logic [RH_W-1:0]  sbox_reg;
    logic [RH_W-1:0]  f_reg;
    logic             adv1, adv2, adv3;
    logic [KEY_W-1:0] mix_next;
    logic [RH_W-1:0]  sbox_next;
    logic [RH_W-1:0]  f_next;

    // stage advance: a stage loads when empty or when its successor moves
    assign adv3 = !v3_reg || m_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign s_tready = adv1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = f_reg;

    // datapath of each stage
    assign mix_next  = des_rf_pkg::des_expand(s_tdata[RH_W-1:0]) ^ s_tdata[RH_W+KEY_W-1:RH_W];
    assign sbox_next = des_rf_pkg::des_sbox_layer(mix_reg);
    assign f_next    = des_rf_pkg::des_perm_p(sbox_reg);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= s_tvalid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv1 && s_tvalid)
        begin
            mix_reg <= mix_next;
        end
        if (adv2 && v1_reg)
        begin
            sbox_reg <= sbox_next;
        end
        if (adv3 && v2_reg)
        begin
            f_reg <= f_next;
        end
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the DES Feistel function block. Each item sent
// carries a right half and a round subkey. A predictor built from the
// standard E, S-box and P tables gives the expected f value for every
// accepted item, and each result is compared in order. Stimulus is a short
// run of directed corner items, then random items under several idle
// patterns on both sides, then a long hold-off on the output side.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int RH_W  = des_rf_pkg::RH_W;
    localparam int KEY_W = des_rf_pkg::KEY_W;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_LIMIT = 2000;

    // expansion E, standard bit numbers (1 = msb), output bit 1 first
    localparam int E_POS [48] = '{
        32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9,
        8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
        16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
        24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
    };

    // permutation P, standard bit numbers, output bit 1 first
    localparam int P_POS [32] = '{
        16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
        2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
    };

    // s-boxes S1..S8, entry index is row * 16 + column
    localparam logic [3:0] S_BOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,9,5,6,11,0,14,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}
    };

    // 6-bit s-box inputs picking each row: row 3 col 0, row 0 col 15, row 2, row 1
    localparam logic [5:0] ROW_SEL [4] = '{6'b100001, 6'b011110, 6'b100000, 6'b000001};

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [RH_W+KEY_W-1:0]   s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [RH_W-1:0]         m_tdata;

    logic [RH_W-1:0]         f_expected [$];
    logic [RH_W-1:0]         f_want;
    int                      mismatches = 0;
    int                      cycle_cnt = 0;
    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    int                      stall_request = 0;
    int                      stall_left = 0;

    des_round_function_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always #5 clk = ~clk;

    // f(R, K): expansion, key mix, s-boxes, permutation P
    function automatic logic [RH_W-1:0] feistel_f(input logic [RH_W-1:0]  r,
                                                  input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] x;
        logic [RH_W-1:0]  s;
        logic [RH_W-1:0]  y;
        logic [5:0]       grp;
        int               row;
        int               col;
        for (int i = 0; i < KEY_W; i++)
        begin
            x[KEY_W-1-i] = r[RH_W-E_POS[i]];
        end
        x = x ^ k;
        for (int b = 0; b < 8; b++)
        begin
            grp = x[KEY_W-1-6*b -: 6];
            row = {grp[5], grp[0]};
            col = grp[4:1];
            s[RH_W-1-4*b -: 4] = S_BOX[b][row*16+col];
        end
        for (int i = 0; i < RH_W; i++)
        begin
            y[RH_W-1-i] = s[RH_W-P_POS[i]];
        end
        return y;
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("Regression FAIL");
            $finish;
        end
    end

    // output side: random idling plus long hold-offs on request
    always @(posedge clk)
    begin
        if (stall_request > 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // predict on each accepted item, compare each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                f_expected.push_back(feistel_f(s_tdata[RH_W-1:0], s_tdata[RH_W +: KEY_W]));
            end
            if (m_tvalid && m_tready)
            begin
                if (f_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual f_out %h",
                             $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    f_want = f_expected.pop_front();
                    if (m_tdata !== f_want)
                    begin
                        $display("%0t: f_out mismatch, expected %h, actual %h",
                                 $time, f_want, m_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

    // offer one item, return at the edge where it is taken
    task automatic send_item(input logic [RH_W-1:0] r, input logic [KEY_W-1:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {k, r};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // change idle rates away from the rising edge
    task automatic set_idle(input int send_pct, input int recv_pct);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(posedge clk);
    endtask

    // all-zero, all-one and alternating halves and keys, wrap-around bits of E
    task automatic test_extremes();
        set_idle(0, 0);
        send_item('0, '0);
        send_item('1, '1);
        send_item('1, '0);
        send_item('0, '1);
        send_item(32'h8000_0000, '0);
        send_item(32'h0000_0001, '0);
        send_item(32'h5555_5555, 48'hAAAA_AAAA_AAAA);
        send_item(32'hAAAA_AAAA, 48'h5555_5555_5555);
        s_tvalid <= 1'b0;
    endtask

    // every s-box driven into each of its four rows
    task automatic test_sbox_rows();
        set_idle(0, 0);
        for (int j = 0; j < 4; j++)
        begin
            send_item('0, {8{ROW_SEL[j]}});
        end
        s_tvalid <= 1'b0;
    endtask

    // one key bit per s-box group, its place in the group stepping by one and wrapping after six groups
    task automatic test_key_bits();
        set_idle(0, 0);
        for (int b = 0; b < 8; b++)
        begin
            send_item(32'h0F0F_0F0F, 48'h1 << (6*b + b%6));
        end
        s_tvalid <= 1'b0;
    endtask

    // random items under the given idle rates
    task automatic test_random(input int n, input int send_pct, input int recv_pct);
        set_idle(send_pct, recv_pct);
        repeat (n)
        begin
            send_item($urandom, {16'($urandom), 32'($urandom)});
        end
        s_tvalid <= 1'b0;
    endtask

    // long output hold-off while items keep coming, so the pipe fills and stalls
    task automatic test_output_hold();
        @(negedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 300;
        @(posedge clk);
        repeat (130)
        begin
            send_item($urandom, {16'($urandom), 32'($urandom)});
        end
        s_tvalid <= 1'b0;
    endtask

    // drain, settle, then report
    task automatic finish_run();
        int waited;
        waited = 0;
        while (f_expected.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (f_expected.size() != 0)
        begin
            $display("%0t: %0d results never arrived, next expected %h",
                     $time, f_expected.size(), f_expected[0]);
            mismatches++;
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    endtask

    // test sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_sbox_rows();
        test_key_bits();
        test_random(500, 31, 58);
        test_random(500, 58, 31);
        test_random(500, 0, 0);
        test_output_hold();
        finish_run();
    end

endmodule
